>>> sv/linear_scan_priority_queue_macros.svh
// Assertion macros of the linear scan priority queue RTL.
`ifndef LINEAR_SCAN_PRIORITY_QUEUE_MACROS_SVH
`define LINEAR_SCAN_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge while reset is released.
`define LSPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lspq assertion failed");

// Checked on every rising edge, during reset as well.
`define LSPQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lspq assertion failed");

`else

`define LSPQ_ASSERT(label, clk, rst_n, prop)
`define LSPQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> sv/lspq_pkg.sv
// Shared constants and types of the linear scan priority queue.
`timescale 1ns / 1ps

package lspq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 16;
    localparam int TAG_BITS      = 16;
    localparam int IDX_BITS      = $clog2(CAPACITY);
    localparam int CNT_BITS      = $clog2(CAPACITY + 1);
    localparam int STATUS_BITS   = 2;

    localparam logic [CNT_BITS-1:0] CAP_COUNT = CNT_BITS'(CAPACITY);

    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [TAG_BITS-1:0]      tag;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        entry_t              wdata;
        logic [IDX_BITS-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]      tag;
        logic [PRIORITY_BITS-1:0] prio;
        logic [STATUS_BITS-1:0]   status;
        logic [CNT_BITS-1:0]      occupancy;
    } result_t;

endpackage

>>> sv/lspq_store.sv
// Entry store: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module lspq_store
(
    input  logic               clk,
    input  lspq_pkg::mem_req_t mem_req,
    output lspq_pkg::entry_t   rd_data
);

    lspq_pkg::entry_t mem [lspq_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        rd_data <= mem[mem_req.raddr];
    end

endmodule

>>> sv/lspq_ctrl.sv
// Sequencer of the priority queue: push, minimum scan and close-up of the store.
`timescale 1ns / 1ps

`include "linear_scan_priority_queue_macros.svh"

module lspq_ctrl
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 operation,
    input  logic [lspq_pkg::TAG_BITS-1:0]        entry_tag,
    input  logic [lspq_pkg::PRIORITY_BITS-1:0]   entry_priority,
    input  logic                                 res_free,
    output logic                                 res_valid,
    output lspq_pkg::result_t                    res,
    output lspq_pkg::mem_req_t                   mem_req,
    input  lspq_pkg::entry_t                     rd_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [lspq_pkg::CNT_BITS-1:0]     count_reg, count_next;
    logic [lspq_pkg::CNT_BITS-1:0]     ptr_reg, ptr_next;
    logic                              pend_reg, pend_next;
    logic [lspq_pkg::IDX_BITS-1:0]     pend_addr_reg, pend_addr_next;
    logic [lspq_pkg::IDX_BITS-1:0]     best_idx_reg, best_idx_next;
    lspq_pkg::entry_t                  best_reg, best_next;
    logic [lspq_pkg::STATUS_BITS-1:0]  status_reg, status_next;
    logic                              op_reg, op_next;
    lspq_pkg::entry_t                  item_reg, item_next;
    logic                              ptr_live;
    logic                              take_new;

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FINISH);
    assign ptr_live  = (ptr_reg < count_reg);

    // The single priority comparator: the entry just read beats the
    // best so far only when strictly lower, so the earliest one wins ties.
    assign take_new  = (pend_addr_reg == '0) || (rd_data.prio < best_reg.prio);

    always_comb
    begin
        mem_req.we    = 1'b0;
        mem_req.waddr = count_reg[lspq_pkg::IDX_BITS-1:0];
        mem_req.wdata = item_reg;
        mem_req.raddr = ptr_reg[lspq_pkg::IDX_BITS-1:0];
        if (state_reg == ST_EXEC && op_reg == lspq_pkg::OP_PUSH && count_reg != lspq_pkg::CAP_COUNT)
        begin
            mem_req.we = 1'b1;
        end
        else if (state_reg == ST_SHIFT && pend_reg)
        begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pend_addr_reg - lspq_pkg::IDX_BITS'(1);
            mem_req.wdata = rd_data;
        end
    end

    always_comb
    begin
        res.status    = status_reg;
        res.occupancy = count_reg;
        if (op_reg == lspq_pkg::OP_REMOVE && status_reg == lspq_pkg::STATUS_OK)
        begin
            res.tag  = best_reg.tag;
            res.prio = best_reg.prio;
        end
        else
        begin
            res.tag  = '0;
            res.prio = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        status_next    = status_reg;
        op_next        = op_reg;
        item_next      = item_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next        = operation;
                    item_next.tag  = entry_tag;
                    item_next.prio = entry_priority;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                status_next = lspq_pkg::STATUS_OK;
                state_next  = ST_FINISH;
                if (op_reg == lspq_pkg::OP_PUSH)
                begin
                    if (count_reg == lspq_pkg::CAP_COUNT)
                    begin
                        status_next = lspq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + lspq_pkg::CNT_BITS'(1);
                    end
                end
                else if (count_reg == '0)
                begin
                    status_next = lspq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Reads run one entry ahead of the compare.
                pend_next      = ptr_live;
                pend_addr_next = ptr_reg[lspq_pkg::IDX_BITS-1:0];
                if (ptr_live)
                begin
                    ptr_next = ptr_reg + lspq_pkg::CNT_BITS'(1);
                end
                if (pend_reg && take_new)
                begin
                    best_next     = rd_data;
                    best_idx_next = pend_addr_reg;
                end
                if (!ptr_live && !pend_reg)
                begin
                    ptr_next   = {1'b0, best_idx_reg} + lspq_pkg::CNT_BITS'(1);
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                // Each entry behind the removed one is read and then written
                // one place lower on the following cycle.
                pend_next      = ptr_live;
                pend_addr_next = ptr_reg[lspq_pkg::IDX_BITS-1:0];
                if (ptr_live)
                begin
                    ptr_next = ptr_reg + lspq_pkg::CNT_BITS'(1);
                end
                if (!ptr_live && !pend_reg)
                begin
                    count_next = count_reg - lspq_pkg::CNT_BITS'(1);
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        status_reg    <= status_next;
        op_reg        <= op_next;
        item_reg      <= item_next;
    end

    `LSPQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= lspq_pkg::CAP_COUNT)
    `LSPQ_ASSERT(a_count_step, clk, rst_n, count_reg != $past(count_reg) |-> (count_reg == $past(count_reg) + lspq_pkg::CNT_BITS'(1) || count_reg == $past(count_reg) - lspq_pkg::CNT_BITS'(1)))
    `LSPQ_ASSERT(a_scan_in_range, clk, rst_n, (state_reg == ST_SCAN && pend_reg) |-> ({1'b0, pend_addr_reg} < count_reg))
    `LSPQ_ASSERT(a_shift_write_order, clk, rst_n, (state_reg == ST_SHIFT && pend_reg) |-> (pend_addr_reg > best_idx_reg))
    `LSPQ_ASSERT(a_count_idle_stable, clk, rst_n, (state_reg == ST_IDLE || state_reg == ST_FINISH || state_reg == ST_SCAN) |=> $stable(count_reg))

endmodule

>>> sv/linear_scan_priority_queue.sv
// Top level of the linear scan priority queue.
`timescale 1ns / 1ps

// Bounded priority queue of lspq_pkg::CAPACITY entries kept in insertion order
// in a single-port-read, single-port-write store. Each accepted item gives one
// result beat. A remove reads every held entry once through the store's read
// port to find the lowest priority (earliest entry on ties), then moves each
// later entry one place down, one entry per cycle. The input is taken one item
// at a time; a finished result waits in an output register so the next item
// can start before it is taken.
module linear_scan_priority_queue
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  operation,
    input  logic [lspq_pkg::TAG_BITS-1:0]         entry_tag,
    input  logic [lspq_pkg::PRIORITY_BITS-1:0]    entry_priority,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lspq_pkg::TAG_BITS-1:0]         out_tag,
    output logic [lspq_pkg::PRIORITY_BITS-1:0]    out_priority,
    output logic [lspq_pkg::STATUS_BITS-1:0]      status,
    output logic [lspq_pkg::CNT_BITS-1:0]         occupancy,
    output logic                                  is_empty
);

    lspq_pkg::mem_req_t mem_req;
    lspq_pkg::entry_t   rd_data;
    lspq_pkg::result_t  res;
    logic               res_valid;
    logic               res_free;
    logic               out_valid_reg, out_valid_next;
    lspq_pkg::result_t  out_reg, out_next;

    assign res_free = !out_valid_reg || out_ready;

    lspq_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .entry_tag      (entry_tag),
        .entry_priority (entry_priority),
        .res_free       (res_free),
        .res_valid      (res_valid),
        .res            (res),
        .mem_req        (mem_req),
        .rd_data        (rd_data)
    );

    lspq_store u_store
    (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_free)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_tag      = out_reg.tag;
    assign out_priority = out_reg.prio;
    assign status       = out_reg.status;
    assign occupancy    = out_reg.occupancy;
    assign is_empty     = (out_reg.occupancy == '0);

endmodule

>>> verif/tb_linear_scan_priority_queue.sv
// Testbench for the linear scan priority queue: directed and random push/remove traffic.
`timescale 1ns / 1ps

module tb_linear_scan_priority_queue;

    localparam int RANDOM_ITEMS     = 1500;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 2 * lspq_pkg::CAPACITY + 8;
    localparam int CYCLE_LIMIT      = 800000;

    // Tracks the held entries in insertion order and the result beats still owed by the block.
    class min_queue_tracker;
        lspq_pkg::entry_t  held_entries[$];
        lspq_pkg::result_t awaited_results[$];
        int                errors;
        int                pushes;
        int                removes;
        int                full_refusals;
        int                empty_removes;
        int                peak_occupancy;

        function void take_item(logic op, logic [lspq_pkg::TAG_BITS-1:0] tag,
                                logic [lspq_pkg::PRIORITY_BITS-1:0] prio);
            lspq_pkg::result_t r;
            lspq_pkg::entry_t  e;
            int                best;
            r        = '0;
            r.status = lspq_pkg::STATUS_OK;
            if (op == lspq_pkg::OP_PUSH)
            begin
                pushes++;
                if (held_entries.size() >= lspq_pkg::CAPACITY)
                begin
                    r.status = lspq_pkg::STATUS_FULL;
                    full_refusals++;
                end
                else
                begin
                    e.tag  = tag;
                    e.prio = prio;
                    held_entries.push_back(e);
                end
            end
            else
            begin
                removes++;
                if (held_entries.size() == 0)
                begin
                    r.status = lspq_pkg::STATUS_EMPTY;
                    empty_removes++;
                end
                else
                begin
                    // Strict compare keeps the earliest entry on equal priorities.
                    best = 0;
                    for (int i = 1; i < held_entries.size(); i++)
                    begin
                        if (held_entries[i].prio < held_entries[best].prio)
                            best = i;
                    end
                    r.tag  = held_entries[best].tag;
                    r.prio = held_entries[best].prio;
                    held_entries.delete(best);
                end
            end
            r.occupancy = lspq_pkg::CNT_BITS'(held_entries.size());
            if (held_entries.size() > peak_occupancy)
                peak_occupancy = held_entries.size();
            awaited_results.push_back(r);
        endfunction

        function void report_field(string field_name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, field_name, want, got);
                errors++;
            end
        endfunction

        function void match_result(logic [lspq_pkg::TAG_BITS-1:0] got_tag,
                                   logic [lspq_pkg::PRIORITY_BITS-1:0] got_prio,
                                   logic [lspq_pkg::STATUS_BITS-1:0] got_status,
                                   logic [lspq_pkg::CNT_BITS-1:0] got_occupancy,
                                   logic got_empty);
            lspq_pkg::result_t r;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result beat with none expected, got tag %0h prio %0h status %0h",
                         $time, got_tag, got_prio, got_status);
                errors++;
                return;
            end
            r = awaited_results.pop_front();
            report_field("out_tag", 32'(r.tag), 32'(got_tag));
            report_field("out_priority", 32'(r.prio), 32'(got_prio));
            report_field("status", 32'(r.status), 32'(got_status));
            report_field("occupancy", 32'(r.occupancy), 32'(got_occupancy));
            report_field("is_empty", 32'(r.occupancy == '0), 32'(got_empty));
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic                               clk            = 1'b0;
    logic                               rst_n          = 1'b0;
    logic                               in_valid       = 1'b0;
    logic                               in_ready;
    logic                               operation      = lspq_pkg::OP_PUSH;
    logic [lspq_pkg::TAG_BITS-1:0]      entry_tag      = '0;
    logic [lspq_pkg::PRIORITY_BITS-1:0] entry_priority = '0;
    logic                               out_valid;
    logic                               out_ready      = 1'b0;
    logic [lspq_pkg::TAG_BITS-1:0]      out_tag;
    logic [lspq_pkg::PRIORITY_BITS-1:0] out_priority;
    logic [lspq_pkg::STATUS_BITS-1:0]   status;
    logic [lspq_pkg::CNT_BITS-1:0]      occupancy;
    logic                               is_empty;

    logic             hold_request = 1'b0;
    int               cycle_count  = 0;
    min_queue_tracker tracker      = new;

    linear_scan_priority_queue i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .entry_tag      (entry_tag),
        .entry_priority (entry_priority),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_tag        (out_tag),
        .out_priority   (out_priority),
        .status         (status),
        .occupancy      (occupancy),
        .is_empty       (is_empty)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            tracker.take_item(operation, entry_tag, entry_priority);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.match_result(out_tag, out_priority, status, occupancy, is_empty);
    end

    // Receiver: stretches of steady, random or sparse readiness, plus a long hold on request.
    initial
    begin
        int rx_mode;
        int rx_left;
        rx_mode = 0;
        rx_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(0, 2);
                    rx_left = $urandom_range(20, 120);
                end
                rx_left--;
                case (rx_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic op, input logic [lspq_pkg::TAG_BITS-1:0] tag,
                             input logic [lspq_pkg::PRIORITY_BITS-1:0] prio);
        @(negedge clk);
        in_valid       <= 1'b1;
        operation      <= op;
        entry_tag      <= tag;
        entry_priority <= prio;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid       <= 1'b0;
            operation      <= 1'($urandom_range(0, 1));
            entry_tag      <= lspq_pkg::TAG_BITS'($urandom);
            entry_priority <= lspq_pkg::PRIORITY_BITS'($urandom);
        end
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [lspq_pkg::PRIORITY_BITS-1:0] pick_priority(input int style);
        case (style)
            0:       return lspq_pkg::PRIORITY_BITS'($urandom);
            1:       return lspq_pkg::PRIORITY_BITS'($urandom_range(0, 7));
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return lspq_pkg::PRIORITY_BITS'(1);
                    2:       return '1 - 1'b1;
                    default: return '1;
                endcase
            end
            default: return lspq_pkg::PRIORITY_BITS'($urandom_range(0, 3));
        endcase
    endfunction

    initial
    begin
        logic [lspq_pkg::TAG_BITS-1:0]      tag_v;
        logic [lspq_pkg::PRIORITY_BITS-1:0] prio_v;
        logic                               op;
        int                                 mode;
        int                                 prio_style;
        int                                 seg_left;
        int                                 burst_left;
        int                                 push_pct;

        seg_left   = 0;
        burst_left = 0;
        mode       = 0;
        prio_style = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Remove on an empty queue, with the ignored fields at all ones.
        send_item(lspq_pkg::OP_REMOVE, '1, '1);

        // Fill to capacity: zero ties at places 2, 3 and last, all ones at 1, mid values elsewhere.
        for (int i = 0; i < lspq_pkg::CAPACITY; i++)
        begin
            tag_v  = (i == 2) ? '1 : (i == 3) ? '0 : lspq_pkg::TAG_BITS'($urandom);
            prio_v = (i == 2 || i == 3 || i == lspq_pkg::CAPACITY - 1) ? '0 :
                     (i == 1) ? '1 : lspq_pkg::PRIORITY_BITS'(16'h8000 + i * 7);
            send_item(lspq_pkg::OP_PUSH, tag_v, prio_v);
        end

        // Push on a full queue is refused.
        send_item(lspq_pkg::OP_PUSH, 16'h5A5A, '0);

        // Earliest of the tied zeros first, then the next one, then the one at the tail.
        repeat (3)
            send_item(lspq_pkg::OP_REMOVE, lspq_pkg::TAG_BITS'($urandom),
                      lspq_pkg::PRIORITY_BITS'($urandom));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (seg_left == 0)
            begin
                mode       = $urandom_range(0, 3);
                prio_style = $urandom_range(0, 3);
                seg_left   = $urandom_range(10, 60);
            end
            seg_left--;

            if (n == 300 || n == 1100)
                hold_request = 1'b1;
            if (n == 600 || n == 1300)
            begin
                wait_for_drain();
                burst_left = 0;
            end

            if (burst_left == 0)
            begin
                idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
            end
            burst_left--;

            case (mode)
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            op = ($urandom_range(0, 99) < push_pct) ? lspq_pkg::OP_PUSH : lspq_pkg::OP_REMOVE;
            send_item(op, lspq_pkg::TAG_BITS'($urandom), pick_priority(prio_style));
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (out_valid)
        begin
            $display("%0t: result beat still offered, expected none", $time);
            tracker.errors++;
        end

        $display("Ran %0d pushes (%0d refused on a full queue) and %0d removes (%0d on empty).",
                 tracker.pushes, tracker.full_refusals, tracker.removes, tracker.empty_removes);
        $display("Peak occupancy %0d of %0d, with long output holds and full drains between.",
                 tracker.peak_occupancy, lspq_pkg::CAPACITY);
        if (tracker.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
